// ===== rtl/hhmd_pkg.sv =====
// package for the hex header message deframer: codes, types and hex decode
`timescale 1ns / 1ps

package hhmd_pkg;

    localparam int DATA_W = 8;
    localparam int CFG_W  = 32;

    localparam logic [DATA_W-1:0] CH_0  = 8'h30;
    localparam logic [DATA_W-1:0] CH_9  = 8'h39;
    localparam logic [DATA_W-1:0] CH_LA = 8'h61;
    localparam logic [DATA_W-1:0] CH_LF = 8'h66;
    localparam logic [DATA_W-1:0] CH_UA = 8'h41;
    localparam logic [DATA_W-1:0] CH_UF = 8'h46;
    localparam logic [DATA_W-1:0] HEX_TEN = 8'd10;

    localparam logic [CFG_W-1:0] TERM_BYTES_RESET = 32'd10;
    localparam logic [2:0]       TERM_LEN_RESET   = 3'd1;

    typedef enum logic [0:0] {
        REG_TERM_BYTES = 1'b0,
        REG_TERM_LEN   = 1'b1
    } reg_index_t;

    typedef enum logic [2:0] {
        STAT_PAYLOAD  = 3'd0,
        STAT_EMPTY    = 3'd1,
        STAT_BAD_CMD  = 3'd2,
        STAT_BAD_LEN  = 3'd3,
        STAT_MISMATCH = 3'd4,
        STAT_OVERRUN  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic rd;
        logic load;
    } hhmd_cmd_t;

    typedef struct packed {
        logic out_free;
        logic start_emit;
        logic emit_last;
    } hhmd_stat_t;

    // returns {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [DATA_W-1:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= CH_0 && ch <= CH_9) begin
            r = {1'b1, 4'(ch - CH_0)};
        end else if (ch >= CH_LA && ch <= CH_LF) begin
            r = {1'b1, 4'(ch - CH_LA + HEX_TEN)};
        end else if (ch >= CH_UA && ch <= CH_UF) begin
            r = {1'b1, 4'(ch - CH_UA + HEX_TEN)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/hex_header_message_deframer_top.sv =====
// top level of the hex header message deframer
`timescale 1ns / 1ps

// Takes one received character per beat and collects a frame: two hex digits of
// command, two hex digits of payload length (either case), then payload, closed
// by a configurable terminator of 1 to 4 bytes. Header errors, length mismatch
// and store overrun each give one result beat with last set; a good frame gives
// its payload bytes, one per beat, the final one with last set, or one empty
// message beat. A byte that produces no result, or a single result, is taken
// whenever the output register is free. A good frame holds off input while the
// frame store is read out one entry at a time, each entry read and then loaded
// into the output register once it is free. Configure only while idle.

module hex_header_message_deframer_top
    import hhmd_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // command, declared_length, byte_index, payload_byte, zero pad
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast
);

    hhmd_cmd_t  cmd;
    hhmd_stat_t stat;
    logic [7:0] command, declared_length, payload_byte;
    logic [5:0] byte_index;

    hhmd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hhmd_datapath #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .rx_byte           (s_tdata),
        .m_tready          (m_tready),
        .m_tvalid          (m_tvalid),
        .m_status          (m_tuser),
        .m_command         (command),
        .m_declared_length (declared_length),
        .m_byte_index      (byte_index),
        .m_payload_byte    (payload_byte),
        .m_last            (m_tlast),
        .cmd               (cmd),
        .stat              (stat)
    );

    assign m_tdata = {2'b00, payload_byte, byte_index, declared_length, command};

endmodule

// ===== rtl/hhmd_ctrl.sv =====
// controller state machine: byte intake and payload read-out sequencing
`timescale 1ns / 1ps

module hhmd_ctrl
    import hhmd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  hhmd_stat_t stat,
    output hhmd_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = stat.out_free;
                if (s_tvalid && stat.out_free) begin
                    cmd.accept = 1'b1;
                    if (stat.start_emit) begin
                        state_next = S_READ;
                    end
                end
            end
            S_READ: begin
                cmd.rd     = 1'b1;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                if (stat.out_free) begin
                    cmd.load   = 1'b1;
                    state_next = stat.emit_last ? S_IDLE : S_READ;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== rtl/hhmd_datapath.sv =====
// datapath: config registers, frame store, header decode, terminator match, output register
`timescale 1ns / 1ps

module hhmd_datapath
    import hhmd_pkg::*;
#(
    parameter int FRAME_DEPTH = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [0:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic [DATA_W-1:0] rx_byte,
    input  logic              m_tready,
    output logic              m_tvalid,
    output logic [2:0]        m_status,
    output logic [7:0]        m_command,
    output logic [7:0]        m_declared_length,
    output logic [5:0]        m_byte_index,
    output logic [7:0]        m_payload_byte,
    output logic              m_last,
    input  hhmd_cmd_t         cmd,
    output hhmd_stat_t        stat
);

    localparam int FW = $clog2(FRAME_DEPTH + 1);
    localparam int AW = $clog2(FRAME_DEPTH);
    localparam int CW = (FW > 8) ? FW + 1 : 9;

    logic [CFG_W-1:0]  term_bytes_reg;
    logic [2:0]        term_len_reg;
    logic [FW-1:0]     fill_reg, fill_next;
    logic [7:0]        cmd_val_reg, cmd_val_next;
    logic [7:0]        len_val_reg, len_val_next;
    logic [31:0]       recent_reg, recent_next;
    logic [DATA_W-1:0] mem [FRAME_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;
    logic [AW-1:0]     emit_idx_reg;
    logic [AW-1:0]     emit_last_reg;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [7:0]        out_cmd_reg, out_len_reg, out_byte_reg;
    logic [5:0]        out_idx_reg;
    logic              out_last_reg;

    logic              overrun;
    logic [FW-1:0]     fill1;
    logic [4:0]        hex_hi, hex_lo;
    logic              bad_cmd, bad_len;
    logic [2:0]        tlen;
    logic              term_hit;
    logic [FW-1:0]     fill_after;
    logic              len_ok;
    logic              single;
    status_t           single_status;
    logic              start_emit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            term_bytes_reg <= TERM_BYTES_RESET;
            term_len_reg   <= TERM_LEN_RESET;
        end else if (cfg_wr_en) begin
            unique case (reg_index_t'(cfg_index))
                REG_TERM_BYTES: term_bytes_reg <= cfg_wdata;
                REG_TERM_LEN:   term_len_reg   <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        overrun      = (fill_reg == FW'(FRAME_DEPTH));
        fill1        = fill_reg + FW'(1);
        recent_next  = {recent_reg[23:0], rx_byte};
        hex_hi       = hex_decode(recent_reg[7:0]);
        hex_lo       = hex_decode(rx_byte);
        bad_cmd      = 1'b0;
        bad_len      = 1'b0;
        cmd_val_next = cmd_val_reg;
        len_val_next = len_val_reg;
        if (fill1 == FW'(2)) begin
            if (hex_hi[4] && hex_lo[4]) begin
                cmd_val_next = {hex_hi[3:0], hex_lo[3:0]};
            end else begin
                bad_cmd = 1'b1;
            end
        end else if (fill1 == FW'(4)) begin
            if (hex_hi[4] && hex_lo[4]) begin
                len_val_next = {hex_hi[3:0], hex_lo[3:0]};
            end else begin
                bad_len = 1'b1;
            end
        end

        priority case (term_len_reg)
            3'd0:                      tlen = 3'd1;
            3'd1, 3'd2, 3'd3, 3'd4:    tlen = term_len_reg;
            default:                   tlen = 3'd4;
        endcase

        term_hit = ({{(CW-FW){1'b0}}, fill1} >= CW'(tlen));
        for (int k = 0; k < 4; k++) begin
            if (k < int'(tlen) && recent_next[8*k +: 8] != term_bytes_reg[8*k +: 8]) begin
                term_hit = 1'b0;
            end
        end

        fill_after = fill1 - FW'(tlen);
        len_ok     = (fill_after >= FW'(4))
                     && (CW'(fill_after) - CW'(4) == CW'(len_val_next));

        single        = 1'b0;
        single_status = STAT_OVERRUN;
        start_emit    = 1'b0;
        fill_next     = fill1;
        priority if (overrun) begin
            single    = 1'b1;
            fill_next = '0;
        end else if (bad_cmd) begin
            single        = 1'b1;
            single_status = STAT_BAD_CMD;
            fill_next     = '0;
        end else if (bad_len) begin
            single        = 1'b1;
            single_status = STAT_BAD_LEN;
            fill_next     = '0;
        end else if (term_hit) begin
            fill_next = '0;
            if (!len_ok) begin
                single        = 1'b1;
                single_status = STAT_MISMATCH;
            end else if (len_val_next == 8'd0) begin
                single        = 1'b1;
                single_status = STAT_EMPTY;
            end else begin
                start_emit = 1'b1;
            end
        end else begin
            fill_next = fill1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            cmd_val_reg <= '0;
            len_val_reg <= '0;
            recent_reg  <= '0;
        end else if (cmd.accept) begin
            fill_reg <= fill_next;
            if (!overrun) begin
                cmd_val_reg <= cmd_val_next;
                len_val_reg <= len_val_next;
                recent_reg  <= recent_next;
            end
        end
    end

    // frame store
    always_ff @(posedge aclk) begin
        if (cmd.accept && !overrun) begin
            mem[fill_reg[AW-1:0]] <= rx_byte;
        end
        if (cmd.rd) begin
            rd_data_reg <= mem[AW'(4) + emit_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && start_emit) begin
            emit_idx_reg  <= '0;
            emit_last_reg <= AW'(len_val_next - 8'd1);
        end else if (cmd.load) begin
            emit_idx_reg <= emit_idx_reg + AW'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if ((cmd.accept && single) || cmd.load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept && single) begin
            out_status_reg <= single_status;
            out_cmd_reg    <= overrun ? cmd_val_reg : cmd_val_next;
            out_len_reg    <= overrun ? len_val_reg : len_val_next;
            out_idx_reg    <= '0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b1;
        end else if (cmd.load) begin
            out_status_reg <= STAT_PAYLOAD;
            out_cmd_reg    <= cmd_val_reg;
            out_len_reg    <= len_val_reg;
            out_idx_reg    <= 6'(emit_idx_reg);
            out_byte_reg   <= rd_data_reg;
            out_last_reg   <= (emit_idx_reg == emit_last_reg);
        end
    end

    assign stat.out_free   = !out_valid_reg || m_tready;
    assign stat.start_emit = start_emit;
    assign stat.emit_last  = (emit_idx_reg == emit_last_reg);

    assign m_tvalid          = out_valid_reg;
    assign m_status          = out_status_reg;
    assign m_command         = out_cmd_reg;
    assign m_declared_length = out_len_reg;
    assign m_byte_index      = out_idx_reg;
    assign m_payload_byte    = out_byte_reg;
    assign m_last            = out_last_reg;

endmodule

// ===== dv/hex_header_message_deframer_top_test.sv =====
// testbench for the hex header message deframer: directed table, random frames, self-checking
`timescale 1ns / 1ps

module hex_header_message_deframer_top_test
    import hhmd_pkg::*;
;

    localparam int FRAME_DEPTH   = 64;
    localparam int SETTLE_CYCLES = 2 * FRAME_DEPTH + 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int DIR_ROWS      = 24;
    localparam int PHASES        = 7;
    localparam int PHASE_BEATS   = 1;

    typedef struct packed {
        status_t    status;
        logic [7:0] command;
        logic [7:0] length;
        logic [5:0] index;
        logic [7:0] data;
        logic       last;
    } frame_result_t;

    typedef struct packed {
        logic [7:0] rx;
        logic       has_exp;
        status_t    status;
        logic [7:0] command;
        logic [7:0] length;
    } directed_row_t;

    typedef enum {
        FR_GOOD,
        FR_MISCOUNT,
        FR_SHORT,
        FR_BAD_CMD,
        FR_BAD_LEN,
        FR_NOISE,
        FR_OVERRUN
    } frame_kind_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [0:0]  cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // rx_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // command, declared_length, byte_index, payload_byte, zero pad
    logic [2:0]  m_tuser;    // status
    logic        m_tlast;

    // deframer shadow state
    logic [7:0]  store_mem [FRAME_DEPTH];
    int          fill_count;
    logic [7:0]  cmd_val;
    logic [7:0]  len_val;
    logic [31:0] recent_rx;
    logic [31:0] term_bytes;
    logic [2:0]  term_len;

    frame_result_t step_results [$];
    frame_result_t pending_results [$];

    int   check_errors;
    int   rx_beats;
    int   burst_left;
    logic hold_req;
    logic hold_done;

    logic [31:0] phase_term [PHASES] = '{32'h0000_000A, 32'h0000_0D0A, 32'hFFFF_FFFF,
                                         32'h0000_0000, 32'h2A2A_2A0A, 32'h5A7E_7E0A,
                                         32'h0000_000A};
    logic [2:0]  phase_len  [PHASES] = '{3'd1, 3'd2, 3'd4, 3'd0, 3'd7, 3'd3, 3'd1};

    directed_row_t directed_rows [DIR_ROWS] = '{
        '{"G",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"x",   1'b1, STAT_BAD_CMD,  8'h00, 8'h00},
        '{"0",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"A",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"z",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"z",   1'b1, STAT_BAD_LEN,  8'h0A, 8'h00},
        '{"f",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"f",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"0",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"0",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{8'h0A, 1'b1, STAT_EMPTY,    8'hFF, 8'h00},
        '{8'h0A, 1'b1, STAT_MISMATCH, 8'hFF, 8'h00},
        '{"F",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"a",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"0",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"2",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{8'h00, 1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{8'hFF, 1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{8'h0A, 1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"9",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"0",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"0",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{"1",   1'b0, STAT_PAYLOAD,  8'h00, 8'h00},
        '{8'h0A, 1'b1, STAT_MISMATCH, 8'h90, 8'h01}
    };

    hex_header_message_deframer_top #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic hex_val(input logic [7:0] ch, output logic [3:0] v);
        v = 4'd0;
        if (ch >= CH_0 && ch <= CH_9) begin
            v = 4'(ch - CH_0);
        end else if (ch >= CH_LA && ch <= CH_LF) begin
            v = 4'(ch - CH_LA + 8'd10);
        end else if (ch >= CH_UA && ch <= CH_UF) begin
            v = 4'(ch - CH_UA + 8'd10);
        end else begin
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_0 + 8'(v);
        end
        return (($urandom_range(0, 1) == 0) ? CH_LA : CH_UA) + 8'(v) - 8'd10;
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] c;
        logic [3:0] v;
        do c = 8'($urandom_range(0, 255)); while (hex_val(c, v));
        return c;
    endfunction

    // 0 acts as 1, 5 to 7 act as 4
    function automatic int term_len_eff();
        if (term_len == 3'd0) begin
            return 1;
        end
        if (term_len > 3'd4) begin
            return 4;
        end
        return int'(term_len);
    endfunction

    function automatic void finish_frame(input status_t st);
        fill_count = 0;
        step_results.push_back('{st, cmd_val, len_val, 6'd0, 8'd0, 1'b1});
    endfunction

    function automatic void deframe_rx(input logic [7:0] b);
        int          tl;
        logic [31:0] mask;
        logic [3:0]  hi;
        logic [3:0]  lo;
        step_results.delete();
        if (fill_count >= FRAME_DEPTH) begin
            finish_frame(STAT_OVERRUN);
            return;
        end
        store_mem[fill_count] = b;
        fill_count++;
        recent_rx = {recent_rx[23:0], b};
        if (fill_count == 2) begin
            if (hex_val(store_mem[0], hi) && hex_val(store_mem[1], lo)) begin
                cmd_val = {hi, lo};
            end else begin
                finish_frame(STAT_BAD_CMD);
                return;
            end
        end else if (fill_count == 4) begin
            if (hex_val(store_mem[2], hi) && hex_val(store_mem[3], lo)) begin
                len_val = {hi, lo};
            end else begin
                finish_frame(STAT_BAD_LEN);
                return;
            end
        end
        tl = term_len_eff();
        if (fill_count < tl) begin
            return;
        end
        mask = (tl == 4) ? 32'hFFFF_FFFF : (32'd1 << (8 * tl)) - 32'd1;
        if ((recent_rx & mask) != (term_bytes & mask)) begin
            return;
        end
        fill_count -= tl;
        if (fill_count < 4 || fill_count - 4 != int'(len_val)) begin
            finish_frame(STAT_MISMATCH);
            return;
        end
        if (len_val == 8'd0) begin
            finish_frame(STAT_EMPTY);
            return;
        end
        for (int i = 0; i < int'(len_val); i++) begin
            step_results.push_back('{STAT_PAYLOAD, cmd_val, len_val, i[5:0],
                                     store_mem[4 + i], 1'(i + 1 == int'(len_val))});
        end
        fill_count = 0;
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic has_exp,
                             input frame_result_t exp_res);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge aclk);
        while (s_tready !== 1'b1) @(posedge aclk);
        burst_left--;
        rx_beats++;
        deframe_rx(b);
        if (has_exp) begin
            pending_results.push_back(exp_res);
        end else begin
            foreach (step_results[i]) pending_results.push_back(step_results[i]);
        end
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] frame_q [$];
        logic [7:0] cmd;
        logic [7:0] len;
        logic [7:0] c;
        int         tl;
        int         max_len;
        int         count;
        int         keep;
        tl      = term_len_eff();
        max_len = 60 - tl;
        cmd     = 8'($urandom_range(0, 255));
        len     = ($urandom_range(0, 9) == 0) ? 8'(max_len) : 8'($urandom_range(0, 10));
        count   = int'(len);
        frame_q.push_back(hex_char(cmd[7:4]));
        frame_q.push_back(hex_char(cmd[3:0]));
        frame_q.push_back(hex_char(len[7:4]));
        frame_q.push_back(hex_char(len[3:0]));
        case (kind)
            FR_MISCOUNT: begin
                count = (int'(len) + $urandom_range(1, 5)) % (max_len + 1);
                if (count == int'(len)) begin
                    count = (len == 8'd0) ? 1 : int'(len) - 1;
                end
            end
            FR_SHORT: begin
                keep = $urandom_range(0, 3);
                while (frame_q.size() > keep) void'(frame_q.pop_back());
            end
            FR_BAD_CMD: begin
                frame_q[$urandom_range(0, 1)] = non_hex_char();
                void'(frame_q.pop_back());
                void'(frame_q.pop_back());
            end
            FR_BAD_LEN: begin
                frame_q[$urandom_range(2, 3)] = non_hex_char();
            end
            FR_NOISE: begin
                frame_q.delete();
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        if (kind == FR_GOOD || kind == FR_MISCOUNT) begin
            repeat (count) begin
                do c = 8'($urandom_range(0, 255)); while (c == term_bytes[7:0]);
                frame_q.push_back(c);
            end
        end
        if (kind == FR_GOOD || kind == FR_MISCOUNT || kind == FR_SHORT) begin
            for (int k = tl - 1; k >= 0; k--) frame_q.push_back(term_bytes[8 * k +: 8]);
        end
        if (kind == FR_OVERRUN) begin
            while (frame_q.size() < FRAME_DEPTH) begin
                do c = 8'($urandom_range(0, 255)); while (c == term_bytes[7:0]);
                frame_q.push_back(c);
            end
            frame_q.push_back(8'($urandom_range(0, 255)));
        end
        foreach (frame_q[i]) send_beat(frame_q[i], 1'b0, '0);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_cfg(input reg_index_t idx, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        if (idx == REG_TERM_BYTES) begin
            term_bytes = value;
        end else begin
            term_len = value[2:0];
        end
    endtask

    // result sink: random stall patterns, one long hold-off on request
    initial begin : result_sink
        int mode;
        int span;
        m_tready <= 1'b0;
        mode = 0;
        span = 0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(5, 60);
                end
                span--;
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= (span % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        frame_result_t got;
        frame_result_t exp_res;
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = '{status_t'(m_tuser), m_tdata[7:0], m_tdata[15:8], m_tdata[21:16],
                    m_tdata[29:22], m_tlast};
            if (pending_results.size() == 0) begin
                check_errors++;
                if (check_errors <= 10) begin
                    $display("unexpected beat: st=%0d cmd=%h len=%h idx=%0d data=%h last=%b",
                             got.status, got.command, got.length, got.index, got.data,
                             got.last);
                end
            end else begin
                exp_res = pending_results.pop_front();
                if (got !== exp_res) begin
                    check_errors++;
                    if (check_errors <= 10) begin
                        $display("beat mismatch: exp st=%0d cmd=%h len=%h idx=%0d data=%h last=%b",
                                 exp_res.status, exp_res.command, exp_res.length,
                                 exp_res.index, exp_res.data, exp_res.last);
                        $display("               got st=%0d cmd=%h len=%h idx=%0d data=%h last=%b",
                                 got.status, got.command, got.length, got.index, got.data,
                                 got.last);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        frame_result_t row_res;
        frame_kind_t   kind;
        int            start;
        int            r;
        int            drain;
        check_errors = 0;
        rx_beats     = 0;
        burst_left   = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        fill_count   = 0;
        cmd_val      = 8'd0;
        len_val      = 8'd0;
        recent_rx    = 32'd0;
        term_bytes   = TERM_BYTES_RESET;
        term_len     = TERM_LEN_RESET;
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_TERM_BYTES;
        cfg_wdata <= 32'd0;
        repeat (9) @(posedge aclk);
        // long hold-off on the result side, which stalls the directed rows once a result is waiting
        hold_req = 1'b1;
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++) begin
            row_res = '{directed_rows[i].status, directed_rows[i].command,
                        directed_rows[i].length, 6'd0, 8'd0, 1'b1};
            send_beat(directed_rows[i].rx, directed_rows[i].has_exp, row_res);
        end
        // store full straight after a clean restart
        send_frame(FR_OVERRUN);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_quiet();
                write_cfg(REG_TERM_BYTES, phase_term[ph]);
                write_cfg(REG_TERM_LEN, {29'd0, phase_len[ph]});
            end
            start = rx_beats;
            while (rx_beats - start < PHASE_BEATS) begin
                r = $urandom_range(0, 99);
                if (r < 50) kind = FR_GOOD;
                else if (r < 62) kind = FR_MISCOUNT;
                else if (r < 68) kind = FR_SHORT;
                else if (r < 76) kind = FR_BAD_CMD;
                else if (r < 84) kind = FR_BAD_LEN;
                else if (r < 96) kind = FR_NOISE;
                else kind = FR_OVERRUN;
                send_frame(kind);
            end
        end

        s_tvalid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain++;
        end
        if (pending_results.size() != 0) begin
            check_errors++;
            $display("%0d expected beats never arrived", pending_results.size());
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (check_errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/hhmd_pkg.sv
rtl/hhmd_ctrl.sv
rtl/hhmd_datapath.sv
rtl/hex_header_message_deframer_top.sv
dv/hex_header_message_deframer_top_test.sv
